// ===== rtl/pcfa_pkg.sv =====
// Shared types and constants of the particle contact force accumulator.
// No dependencies; every other file of the block refers to it by scoped names.
package pcfa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 31;
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 8;
  localparam int TALLY_W   = 8;

  // iteration counts of the bit-serial units
  localparam int MUL_STEPS  = 34;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 64;
  localparam int CNT_W      = 7;

  localparam logic [CFG_W-1:0] RADIUS_RST = 31'd65536;
  localparam logic [CFG_W-1:0] HALF_RST   = 31'd655360;
  localparam logic [CFG_W-1:0] SPRING_RST = 31'd65536;
  localparam logic [CFG_W-1:0] DAMP_RST   = 31'd6554;

  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 2'd0,
    KIND_NEIGH  = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_HALF   = 2'd1,
    REG_SPRING = 2'd2,
    REG_DAMP   = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_LD,
    ST_MUL,
    ST_SQRT,
    ST_DIV,
    ST_SPR_LD,
    ST_DMP_LD,
    ST_ADD,
    ST_FIN_Y,
    ST_FIN_XZ,
    ST_WDMP_LD,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    OP_SQ,
    OP_MAG,
    OP_SPR,
    OP_DMP,
    OP_WALL,
    OP_WDMP
  } op_e;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } term_t;

endpackage

// ===== rtl/pcfa_in_if.sv =====
// Input word channel of the contact force accumulator.
// Depends on pcfa_pkg for field widths.
interface pcfa_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [pcfa_pkg::KIND_W-1:0]           kind;
  logic signed [pcfa_pkg::DATA_W-1:0]    pos_x;
  logic signed [pcfa_pkg::DATA_W-1:0]    pos_y;
  logic signed [pcfa_pkg::DATA_W-1:0]    pos_z;
  logic signed [pcfa_pkg::DATA_W-1:0]    vel_x;
  logic signed [pcfa_pkg::DATA_W-1:0]    vel_y;
  logic signed [pcfa_pkg::DATA_W-1:0]    vel_z;

  modport source (output valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

// ===== rtl/pcfa_out_if.sv =====
// Result word channel of the contact force accumulator.
// Depends on pcfa_pkg for field widths.
interface pcfa_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pcfa_pkg::DATA_W-1:0]    force_x;
  logic signed [pcfa_pkg::DATA_W-1:0]    force_y;
  logic signed [pcfa_pkg::DATA_W-1:0]    force_z;
  logic                                  wall_contact;
  logic [pcfa_pkg::TALLY_W-1:0]          contact_count;
  logic                                  saturated;

  modport source (output valid, force_x, force_y, force_z, wall_contact, contact_count,
                  saturated, input ready);
  modport sink (input valid, force_x, force_y, force_z, wall_contact, contact_count,
                saturated, output ready);
endinterface

// ===== rtl/pcfa_cfg_if.sv =====
// Configuration write channel of the contact force accumulator.
// Depends on pcfa_pkg for index and data widths.
interface pcfa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pcfa_pkg::IDX_W-1:0]    index;
  logic [pcfa_pkg::DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/particle_contact_force_accumulator_top.sv =====
// Top level of the particle contact force accumulator (spring-dashpot contacts).
// Depends on pcfa_pkg and the interfaces pcfa_in_if, pcfa_out_if, pcfa_cfg_if.
//
//   channel     dir  handshake      payload
//   in_word_i   in   valid/ready    kind, pos_x/y/z, vel_x/y/z
//   res_word_o  out  valid/ready    force_x/y/z, wall_contact, contact_count, saturated
//   cfg_i       in   valid/ready    index, data (register index 0..3)
//
// Work per word: a start word or an unused kind is handled without leaving idle; a neighbour
// that is dropped ends after at most three squares and the root; a touching neighbour runs
// ten products through the shared bit-serial multiplier and three quotients through the
// divider. A finish word adds any wall terms, then waits on the result register if needed.
// Reset loads the register defaults and clears the own state and the accumulator.
// in_word_i is ready only in idle; a finished result waits in its output register
// while new words are taken, and a second finish holds until that word is taken.
module particle_contact_force_accumulator_top #(
  parameter int FracBits = pcfa_pkg::FRAC_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pcfa_in_if.sink        in_word_i,
  pcfa_out_if.source     res_word_o,
  pcfa_cfg_if.sink       cfg_i
);

  localparam int PW = 2 * pcfa_pkg::DATA_W + 2;   // product register width

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    mag33 = v[32] ? n : v;
  endfunction

  function automatic logic [33:0] mag35(input logic signed [34:0] v);
    logic signed [34:0] n;
    n = -v;
    mag35 = v[34] ? n[33:0] : v[33:0];
  endfunction

  function automatic pcfa_pkg::term_t clip_term(input logic neg, input logic [63:0] mag);
    pcfa_pkg::term_t t;
    logic [63:0] n;
    n = -mag;
    if (neg) begin
      if (mag > 64'h8000_0000) t = '{ovf: 1'b1, val: 32'h8000_0000};
      else t = '{ovf: 1'b0, val: n[31:0]};
    end else begin
      if (mag > 64'h7FFF_FFFF) t = '{ovf: 1'b1, val: 32'h7FFF_FFFF};
      else t = '{ovf: 1'b0, val: mag[31:0]};
    end
    clip_term = t;
  endfunction

  // configuration registers
  logic [30:0] rad_q, whs_q, kc_q, dc_q;

  // own particle and latched neighbour differences
  logic signed [31:0] own_p_q [3];
  logic signed [31:0] own_v_q [3];
  logic signed [32:0] d_q [3];
  logic signed [32:0] dv_q [3];

  // sequencer and accumulator
  pcfa_pkg::state_e state_q, state_d;
  pcfa_pkg::op_e    op_q, op_d;
  logic [1:0]       ax_q, ax_d;
  logic [pcfa_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic signed [31:0] sum_q [3];
  logic signed [31:0] sum_d [3];
  logic [7:0]       tally_q, tally_d;
  logic             ovf_q, ovf_d;
  logic             wall_q, wall_d;
  logic             tneg_q, tneg_d;
  logic [31:0]      term_q, term_d;
  logic [31:0]      m_q, m_d;

  // bit-serial units
  logic [31:0]      ma_q, ma_d;
  logic [PW-1:0]    mp_q, mp_d;
  logic [63:0]      ssum_q, ssum_d;
  logic [63:0]      sq_q, sq_d;
  logic [31:0]      root_q, root_d;
  logic [33:0]      rem_q, rem_d;
  logic [63:0]      dq_q, dq_d;
  logic [31:0]      drem_q, drem_d;

  // result register
  logic             ovalid_q, ovalid_d;
  logic signed [31:0] fx_q, fx_d, fy_q, fy_d, fz_q, fz_d;
  logic             owall_q, owall_d, osat_q, osat_d;
  logic [7:0]       ocnt_q, ocnt_d;

  logic             in_hs;
  logic [31:0]      two_r;
  logic [32:0]      dmag, dvmag, ovmag;
  logic [32:0]      mul_s;
  logic [PW-1:0]    mq;
  logic [31:0]      mq_cap;
  logic             mq_ovf;
  pcfa_pkg::term_t  mul_term, div_term;
  logic [64:0]      ss_add;
  logic [35:0]      sq_rs, sq_tr;
  logic             sq_ge;
  logic [32:0]      dv_rs;
  logic             dv_ge;
  logic signed [32:0] add_s;
  logic signed [34:0] rad35, whs35, gnd_v, lo_v, hi_v;

  assign in_word_i.ready = (state_q == pcfa_pkg::ST_IDLE);
  assign in_hs           = in_word_i.valid && in_word_i.ready;
  assign cfg_i.ready     = 1'b1;

  assign res_word_o.valid         = ovalid_q;
  assign res_word_o.force_x       = fx_q;
  assign res_word_o.force_y       = fy_q;
  assign res_word_o.force_z       = fz_q;
  assign res_word_o.wall_contact  = owall_q;
  assign res_word_o.contact_count = ocnt_q;
  assign res_word_o.saturated     = osat_q;

  assign two_r = {rad_q, 1'b0};
  assign dmag  = mag33(d_q[ax_q]);
  assign dvmag = mag33(dv_q[ax_q]);
  assign ovmag = mag33(33'(own_v_q[ax_q]));

  // multiplier step: add the multiplicand on a set low bit, shift right one place
  assign mul_s  = {1'b0, mp_q[PW-1:34]} + (mp_q[0] ? {1'b0, ma_q} : 33'd0);
  // scaled product, capped at 32 bits unsigned
  assign mq     = mp_q >> FracBits;
  assign mq_ovf = |mq[PW-1:32];
  assign mq_cap = mq_ovf ? 32'hFFFF_FFFF : mq[31:0];
  assign mul_term = clip_term(tneg_q, {32'd0, mq_cap});
  assign div_term = clip_term(tneg_q, dq_q);

  assign ss_add = {1'b0, ssum_q} + {1'b0, mp_q[63:0]};

  // square root: one base-4 digit a step
  assign sq_rs = {rem_q, sq_q[63:62]};
  assign sq_tr = {2'b00, root_q, 2'b01};
  assign sq_ge = sq_rs >= sq_tr;

  // restoring divide by the distance, one quotient bit a step
  assign dv_rs = {drem_q, dq_q[63]};
  assign dv_ge = dv_rs >= {1'b0, root_q};

  assign add_s = 33'(sum_q[ax_q]) + 33'($signed(term_q));

  // wall geometry
  assign rad35 = $signed({4'd0, rad_q});
  assign whs35 = $signed({4'd0, whs_q});
  assign gnd_v = rad35 - 35'(own_p_q[1]);
  assign lo_v  = 35'(own_p_q[ax_q]) - rad35 + whs35;
  assign hi_v  = 35'(own_p_q[ax_q]) + rad35 - whs35;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= pcfa_pkg::RADIUS_RST;
      whs_q <= pcfa_pkg::HALF_RST;
      kc_q  <= pcfa_pkg::SPRING_RST;
      dc_q  <= pcfa_pkg::DAMP_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        8'(pcfa_pkg::REG_RADIUS): rad_q <= cfg_i.data[30:0];
        8'(pcfa_pkg::REG_HALF):   whs_q <= cfg_i.data[30:0];
        8'(pcfa_pkg::REG_SPRING): kc_q  <= cfg_i.data[30:0];
        8'(pcfa_pkg::REG_DAMP):   dc_q  <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  // own state loads on start; a neighbour word leaves only its differences
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_p_q <= '{default: '0};
      own_v_q <= '{default: '0};
    end else if (in_hs && in_word_i.kind == pcfa_pkg::KIND_START) begin
      own_p_q[0] <= in_word_i.pos_x;
      own_p_q[1] <= in_word_i.pos_y;
      own_p_q[2] <= in_word_i.pos_z;
      own_v_q[0] <= in_word_i.vel_x;
      own_v_q[1] <= in_word_i.vel_y;
      own_v_q[2] <= in_word_i.vel_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs && in_word_i.kind == pcfa_pkg::KIND_NEIGH) begin
      d_q[0]  <= 33'(in_word_i.pos_x) - 33'(own_p_q[0]);
      d_q[1]  <= 33'(in_word_i.pos_y) - 33'(own_p_q[1]);
      d_q[2]  <= 33'(in_word_i.pos_z) - 33'(own_p_q[2]);
      dv_q[0] <= 33'(in_word_i.vel_x) - 33'(own_v_q[0]);
      dv_q[1] <= 33'(in_word_i.vel_y) - 33'(own_v_q[1]);
      dv_q[2] <= 33'(in_word_i.vel_z) - 33'(own_v_q[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pcfa_pkg::ST_IDLE;
      sum_q    <= '{default: '0};
      tally_q  <= '0;
      ovf_q    <= 1'b0;
      wall_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sum_q    <= sum_d;
      tally_q  <= tally_d;
      ovf_q    <= ovf_d;
      wall_q   <= wall_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    ax_q    <= ax_d;
    cnt_q   <= cnt_d;
    tneg_q  <= tneg_d;
    term_q  <= term_d;
    m_q     <= m_d;
    ma_q    <= ma_d;
    mp_q    <= mp_d;
    ssum_q  <= ssum_d;
    sq_q    <= sq_d;
    root_q  <= root_d;
    rem_q   <= rem_d;
    dq_q    <= dq_d;
    drem_q  <= drem_d;
    fx_q    <= fx_d;
    fy_q    <= fy_d;
    fz_q    <= fz_d;
    owall_q <= owall_d;
    ocnt_q  <= ocnt_d;
    osat_q  <= osat_d;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    ax_d     = ax_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    tally_d  = tally_q;
    ovf_d    = ovf_q;
    wall_d   = wall_q;
    tneg_d   = tneg_q;
    term_d   = term_q;
    m_d      = m_q;
    ma_d     = ma_q;
    mp_d     = mp_q;
    ssum_d   = ssum_q;
    sq_d     = sq_q;
    root_d   = root_q;
    rem_d    = rem_q;
    dq_d     = dq_q;
    drem_d   = drem_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    fz_d     = fz_q;
    owall_d  = owall_q;
    ocnt_d   = ocnt_q;
    osat_d   = osat_q;
    ovalid_d = ovalid_q && !res_word_o.ready;

    case (state_q)
      pcfa_pkg::ST_IDLE: begin
        if (in_hs) begin
          case (in_word_i.kind)
            pcfa_pkg::KIND_START: begin
              sum_d   = '{default: '0};
              tally_d = '0;
              ovf_d   = 1'b0;
            end
            pcfa_pkg::KIND_NEIGH: begin
              ssum_d  = '0;
              ax_d    = 2'd0;
              state_d = pcfa_pkg::ST_SQ_LD;
            end
            pcfa_pkg::KIND_FINISH: begin
              wall_d  = 1'b0;
              state_d = pcfa_pkg::ST_FIN_Y;
            end
            default: ;
          endcase
        end
      end

      pcfa_pkg::ST_SQ_LD: begin
        // drop the neighbour as soon as one axis is out of reach
        if (dmag >= {1'b0, two_r}) begin
          state_d = pcfa_pkg::ST_IDLE;
        end else begin
          ma_d    = dmag[31:0];
          mp_d    = {32'd0, 1'b0, dmag};
          cnt_d   = '0;
          op_d    = pcfa_pkg::OP_SQ;
          state_d = pcfa_pkg::ST_MUL;
        end
      end

      pcfa_pkg::ST_MUL: begin
        if (cnt_q != pcfa_pkg::CNT_W'(pcfa_pkg::MUL_STEPS)) begin
          mp_d  = {mul_s, mp_q[33:1]};
          cnt_d = cnt_q + 1'b1;
        end else begin
          case (op_q)
            pcfa_pkg::OP_SQ: begin
              if (ss_add[64]) begin
                state_d = pcfa_pkg::ST_IDLE;
              end else if (ax_q == 2'd2) begin
                if (ss_add[63:0] == 64'd0) begin
                  state_d = pcfa_pkg::ST_IDLE;
                end else begin
                  sq_d    = ss_add[63:0];
                  root_d  = '0;
                  rem_d   = '0;
                  cnt_d   = '0;
                  state_d = pcfa_pkg::ST_SQRT;
                end
              end else begin
                ssum_d  = ss_add[63:0];
                ax_d    = ax_q + 2'd1;
                state_d = pcfa_pkg::ST_SQ_LD;
              end
            end
            pcfa_pkg::OP_MAG: begin
              m_d     = mq_cap;
              ovf_d   = ovf_q | mq_ovf;
              ax_d    = 2'd0;
              state_d = pcfa_pkg::ST_SPR_LD;
            end
            pcfa_pkg::OP_SPR: begin
              dq_d    = mp_q[63:0];
              drem_d  = '0;
              cnt_d   = '0;
              state_d = pcfa_pkg::ST_DIV;
            end
            default: begin
              term_d  = mul_term.val;
              ovf_d   = ovf_q | mq_ovf | mul_term.ovf;
              state_d = pcfa_pkg::ST_ADD;
            end
          endcase
        end
      end

      pcfa_pkg::ST_SQRT: begin
        if (cnt_q != pcfa_pkg::CNT_W'(pcfa_pkg::SQRT_STEPS)) begin
          sq_d   = {sq_q[61:0], 2'b00};
          rem_d  = sq_ge ? 34'(sq_rs - sq_tr) : sq_rs[33:0];
          root_d = {root_q[30:0], sq_ge};
          cnt_d  = cnt_q + 1'b1;
        end else if (({1'b0, root_q} + 33'd1) < {1'b0, two_r}) begin
          if (tally_q != 8'hFF) tally_d = tally_q + 8'd1;
          ma_d    = {1'b0, kc_q};
          mp_d    = {34'd0, two_r - root_q};
          cnt_d   = '0;
          op_d    = pcfa_pkg::OP_MAG;
          state_d = pcfa_pkg::ST_MUL;
        end else begin
          state_d = pcfa_pkg::ST_IDLE;
        end
      end

      pcfa_pkg::ST_SPR_LD: begin
        ma_d    = m_q;
        mp_d    = {32'd0, 1'b0, dmag};
        tneg_d  = !d_q[ax_q][32];
        cnt_d   = '0;
        op_d    = pcfa_pkg::OP_SPR;
        state_d = pcfa_pkg::ST_MUL;
      end

      pcfa_pkg::ST_DIV: begin
        if (cnt_q != pcfa_pkg::CNT_W'(pcfa_pkg::DIV_STEPS)) begin
          dq_d   = {dq_q[62:0], dv_ge};
          drem_d = dv_ge ? 32'(dv_rs - {1'b0, root_q}) : dv_rs[31:0];
          cnt_d  = cnt_q + 1'b1;
        end else begin
          term_d  = div_term.val;
          ovf_d   = ovf_q | div_term.ovf;
          state_d = pcfa_pkg::ST_ADD;
        end
      end

      pcfa_pkg::ST_DMP_LD: begin
        ma_d    = {1'b0, dc_q};
        mp_d    = {32'd0, 1'b0, dvmag};
        tneg_d  = dv_q[ax_q][32];
        cnt_d   = '0;
        op_d    = pcfa_pkg::OP_DMP;
        state_d = pcfa_pkg::ST_MUL;
      end

      pcfa_pkg::ST_ADD: begin
        // saturate the axis sum, then advance to the next term
        if (add_s[32] != add_s[31]) begin
          sum_d[ax_q] = add_s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          ovf_d       = 1'b1;
        end else begin
          sum_d[ax_q] = add_s[31:0];
        end
        case (op_q)
          pcfa_pkg::OP_SPR: begin
            if (ax_q == 2'd2) begin
              ax_d    = 2'd0;
              state_d = pcfa_pkg::ST_DMP_LD;
            end else begin
              ax_d    = ax_q + 2'd1;
              state_d = pcfa_pkg::ST_SPR_LD;
            end
          end
          pcfa_pkg::OP_DMP: begin
            if (ax_q == 2'd2) begin
              state_d = pcfa_pkg::ST_IDLE;
            end else begin
              ax_d    = ax_q + 2'd1;
              state_d = pcfa_pkg::ST_DMP_LD;
            end
          end
          pcfa_pkg::OP_WALL: begin
            if (ax_q == 2'd1) begin
              ax_d    = 2'd0;
              state_d = pcfa_pkg::ST_FIN_XZ;
            end else if (ax_q == 2'd0) begin
              ax_d    = 2'd2;
              state_d = pcfa_pkg::ST_FIN_XZ;
            end else begin
              ax_d    = 2'd0;
              state_d = pcfa_pkg::ST_WDMP_LD;
            end
          end
          pcfa_pkg::OP_WDMP: begin
            if (ax_q == 2'd2) begin
              state_d = pcfa_pkg::ST_EMIT;
            end else begin
              ax_d    = ax_q + 2'd1;
              state_d = pcfa_pkg::ST_WDMP_LD;
            end
          end
          default: state_d = pcfa_pkg::ST_IDLE;
        endcase
      end

      pcfa_pkg::ST_FIN_Y: begin
        // ground contact pushes up
        if (gnd_v > 35'sd0) begin
          wall_d  = 1'b1;
          ma_d    = {1'b0, kc_q};
          mp_d    = {32'd0, mag35(gnd_v)};
          tneg_d  = 1'b0;
          cnt_d   = '0;
          ax_d    = 2'd1;
          op_d    = pcfa_pkg::OP_WALL;
          state_d = pcfa_pkg::ST_MUL;
        end else begin
          ax_d    = 2'd0;
          state_d = pcfa_pkg::ST_FIN_XZ;
        end
      end

      pcfa_pkg::ST_FIN_XZ: begin
        if (lo_v < 35'sd0 || hi_v > 35'sd0) begin
          wall_d  = 1'b1;
          ma_d    = {1'b0, kc_q};
          mp_d    = {32'd0, (lo_v < 35'sd0) ? mag35(lo_v) : mag35(hi_v)};
          tneg_d  = !(lo_v < 35'sd0);
          cnt_d   = '0;
          op_d    = pcfa_pkg::OP_WALL;
          state_d = pcfa_pkg::ST_MUL;
        end else if (ax_q == 2'd0) begin
          ax_d = 2'd2;
        end else begin
          ax_d    = 2'd0;
          state_d = wall_q ? pcfa_pkg::ST_WDMP_LD : pcfa_pkg::ST_EMIT;
        end
      end

      pcfa_pkg::ST_WDMP_LD: begin
        ma_d    = {1'b0, dc_q};
        mp_d    = {32'd0, 1'b0, ovmag};
        tneg_d  = !own_v_q[ax_q][31];
        cnt_d   = '0;
        op_d    = pcfa_pkg::OP_WDMP;
        state_d = pcfa_pkg::ST_MUL;
      end

      pcfa_pkg::ST_EMIT: begin
        // hold until the result register is free
        if (!ovalid_q || res_word_o.ready) begin
          fx_d     = sum_q[0];
          fy_d     = sum_q[1];
          fz_d     = sum_q[2];
          owall_d  = wall_q;
          ocnt_d   = tally_q;
          osat_d   = ovf_q;
          ovalid_d = 1'b1;
          sum_d    = '{default: '0};
          tally_d  = '0;
          ovf_d    = 1'b0;
          state_d  = pcfa_pkg::ST_IDLE;
        end
      end

      default: state_d = pcfa_pkg::ST_IDLE;
    endcase
  end

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcfa_pkg::ST_DIV || state_q == pcfa_pkg::ST_SPR_LD) |-> (root_q != 32'd0))
    else $error("divide by a zero distance");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> (tally_q == 8'd0 && !ovf_q && sum_q[0] == 32'sd0))
    else $error("accumulator not cleared on emit");

  a_wdmp_wall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcfa_pkg::ST_WDMP_LD) |-> wall_q)
    else $error("wall damping without wall contact");

endmodule

// ===== tb/pcfa_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench-side probe interface of the contact force accumulator bench.
// Depends on nothing; the block's own interfaces come from rtl/ and are reused by the top.
interface pcfa_tb_probe_if (input logic clk_i);
  logic stall_hold;
  modport source (output stall_hold);
  modport sink (input stall_hold);
endinterface

// ===== tb/particle_contact_force_accumulator_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench of particle_contact_force_accumulator_top: drives start, neighbour and finish
// words under random idling, predicts each force result in a scoreboard class and checks it.
// Depends on pcfa_pkg, pcfa_in_if, pcfa_out_if, pcfa_cfg_if and pcfa_tb_probe_if.
module particle_contact_force_accumulator_top_tb;

  typedef struct {
    logic signed [31:0] fx, fy, fz;
    logic wall;
    logic [7:0] cnt;
    logic sat;
  } force_res_t;

  // Spring-dashpot predictor plus the queue of expected force words.
  class force_board;
    longint unsigned radius, half, spring, damp;
    longint own_p[3], own_v[3], acc[3];
    int unsigned tally;
    bit ovf;
    force_res_t pending[$];
    int errors;

    function new();
      radius = 65536; half = 655360; spring = 65536; damp = 6554;
      foreach (own_p[i]) begin own_p[i] = 0; own_v[i] = 0; end
      clear_acc();
      errors = 0;
    endfunction

    function void clear_acc();
      foreach (acc[i]) acc[i] = 0;
      tally = 0; ovf = 0;
    endfunction

    function void write_reg(pcfa_pkg::reg_e idx, logic [31:0] val);
      longint unsigned v;
      v = val[30:0];
      case (idx)
        pcfa_pkg::REG_RADIUS: radius = v;
        pcfa_pkg::REG_HALF:   half = v;
        pcfa_pkg::REG_SPRING: spring = v;
        pcfa_pkg::REG_DAMP:   damp = v;
        default: ;
      endcase
    endfunction

    function longint unsigned abs64(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint unsigned scale(longint unsigned c, longint unsigned v);
      longint unsigned hi, lo, r;
      hi = c * (v >> 16);
      lo = c * (v & 64'hFFFF);
      if (hi >= (64'd1 << 47)) begin ovf = 1; return 64'hFFFF_FFFF; end
      r = ((hi << 16) + lo) >> pcfa_pkg::FRAC_BITS;
      if (r > 64'hFFFF_FFFF) begin ovf = 1; return 64'hFFFF_FFFF; end
      return r;
    endfunction

    function longint clip(bit neg, longint unsigned m);
      if (neg) begin
        if (m > 64'h8000_0000) begin ovf = 1; return -64'sh8000_0000; end
        return -longint'(m);
      end
      if (m > 64'h7FFF_FFFF) begin ovf = 1; return 64'sh7FFF_FFFF; end
      return longint'(m);
    endfunction

    function void add_axis(int ax, longint t);
      longint s;
      s = acc[ax] + t;
      if (s > 64'sh7FFF_FFFF) begin s = 64'sh7FFF_FFFF; ovf = 1; end
      else if (s < -64'sh8000_0000) begin s = -64'sh8000_0000; ovf = 1; end
      acc[ax] = s;
    endfunction

    function void add_prod(int ax, longint unsigned c, longint v, bit negate);
      longint unsigned m;
      m = scale(c, abs64(v));
      add_axis(ax, clip((v < 0) != negate, m));
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned res, b;
      res = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin n -= res + b; res = (res >> 1) + b; end
        else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    function void add_neighbour(longint p[3], longint v[3]);
      longint unsigned two_r, total, sep, m, a, sq, t;
      longint d[3];
      two_r = 2 * radius; total = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = p[i] - own_p[i];
        a = abs64(d[i]);
        if (a >= two_r) return;
        sq = a * a;
        if (total > 64'hFFFF_FFFF_FFFF_FFFF - sq) return;
        total += sq;
      end
      if (total == 0) return;
      sep = root(total);
      if (!(sep + 1 < two_r)) return;
      if (tally < 255) tally++;
      m = scale(spring, two_r - sep);
      for (int i = 0; i < 3; i++) begin
        t = (m * abs64(d[i])) / sep;
        add_axis(i, clip(d[i] >= 0, t));
      end
      for (int i = 0; i < 3; i++) add_prod(i, damp, v[i] - own_v[i], 0);
    endfunction

    // Note one accepted input word and queue its result, if any.
    function void note_word(pcfa_pkg::kind_e k, logic [31:0] f[6]);
      longint p[3], v[3], r, w;
      bit wall;
      force_res_t res;
      for (int i = 0; i < 3; i++) begin
        p[i] = longint'($signed(f[i])); v[i] = longint'($signed(f[3+i]));
      end
      r = longint'(radius); w = longint'(half); wall = 0;
      case (k)
        pcfa_pkg::KIND_START: begin
          own_p = p; own_v = v; clear_acc();
        end
        pcfa_pkg::KIND_NEIGH: add_neighbour(p, v);
        pcfa_pkg::KIND_FINISH: begin
          if (own_p[1] - r < 0) begin wall = 1; add_prod(1, spring, r - own_p[1], 0); end
          for (int i = 0; i < 3; i += 2) begin
            if (own_p[i] - r < -w) begin
              wall = 1; add_prod(i, spring, -w - own_p[i] + r, 0);
            end else if (own_p[i] + r > w) begin
              wall = 1; add_prod(i, spring, w - own_p[i] - r, 0);
            end
          end
          if (wall) for (int i = 0; i < 3; i++) add_prod(i, damp, own_v[i], 1);
          res.fx = acc[0][31:0]; res.fy = acc[1][31:0]; res.fz = acc[2][31:0];
          res.wall = wall; res.cnt = tally[7:0]; res.sat = ovf;
          pending.push_back(res);
          clear_acc();
        end
        default: ;
      endcase
    endfunction

    function void report(string fld, longint e, longint a);
      errors++;
      if (errors <= 10) $display("mismatch %s: expected %0h got %0h", fld, e, a);
    endfunction

    // Check one accepted result word against the oldest expectation.
    function void check_word(force_res_t got);
      force_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word");
        return;
      end
      e = pending.pop_front();
      if (got.fx !== e.fx) report("force_x", e.fx, got.fx);
      if (got.fy !== e.fy) report("force_y", e.fy, got.fy);
      if (got.fz !== e.fz) report("force_z", e.fz, got.fz);
      if (got.wall !== e.wall) report("wall_contact", e.wall, got.wall);
      if (got.cnt !== e.cnt) report("contact_count", e.cnt, got.cnt);
      if (got.sat !== e.sat) report("saturated", e.sat, got.sat);
    endfunction
  endclass

  logic clk_i, rst_ni;
  pcfa_in_if  in_ch();
  pcfa_out_if res_ch();
  pcfa_cfg_if cfg_ch();
  pcfa_tb_probe_if probe (.clk_i(clk_i));   // stall_hold: long hold-off of the result side

  particle_contact_force_accumulator_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_word_i(in_ch.sink), .res_word_o(res_ch.source), .cfg_i(cfg_ch.sink)
  );

  force_board board = new();
  int send_idle_pct, recv_idle_pct;

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Limit: a watchdog that reports errors and stops the run if the test hangs.
  initial begin
    #(20 * 5000000);
    $display("DONE: errors detected");
    $finish;
  end

  // Sample results at the rising edge; drive ready at the falling edge.
  always @(posedge clk_i) begin
    force_res_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.fx = res_ch.force_x; got.fy = res_ch.force_y; got.fz = res_ch.force_z;
      got.wall = res_ch.wall_contact; got.cnt = res_ch.contact_count;
      got.sat = res_ch.saturated;
      board.check_word(got);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) res_ch.ready <= 1'b0;
    else res_ch.ready <= !probe.stall_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one word, idling at random first; hold it until taken.
  task automatic send_word(pcfa_pkg::kind_e k, logic [31:0] f[6]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1; in_ch.kind <= k;
    in_ch.pos_x <= f[0]; in_ch.pos_y <= f[1]; in_ch.pos_z <= f[2];
    in_ch.vel_x <= f[3]; in_ch.vel_y <= f[4]; in_ch.vel_z <= f[5];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_word(k, f);
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_cfg(pcfa_pkg::reg_e idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= 8'(idx); cfg_ch.data <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drain all expected words, then let a finish or long neighbour settle.
  task automatic drain();
    go_idle();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (800) @(negedge clk_i);
  endtask

  function automatic logic [31:0] near(logic [31:0] base, int unsigned span);
    return base + 32'($signed($urandom_range(2 * span)) - $signed(span));
  endfunction

  function automatic logic [31:0] any_val();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  // One particle: start, a few neighbours near it, finish. Sometimes broken.
  task automatic run_particle(int unsigned spread);
    logic [31:0] own[6], f[6];
    int n;
    for (int i = 0; i < 6; i++)
      own[i] = ($urandom_range(9) == 0) ? any_val()
             : 32'($signed($urandom_range(2 * spread)) - $signed(spread));
    if ($urandom_range(15) != 0) send_word(pcfa_pkg::KIND_START, own);
    n = $urandom_range(4);
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < 3; i++) f[i] = near(own[i], 32'(3 * board.radius + 1));
      for (int i = 3; i < 6; i++) f[i] = ($urandom_range(7) == 0) ? any_val() : near(own[i], 200000);
      if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) f[i] = own[i];
      if ($urandom_range(19) == 0) for (int i = 0; i < 6; i++) f[i] = any_val();
      send_word(($urandom_range(29) == 0) ? pcfa_pkg::KIND_NONE : pcfa_pkg::KIND_NEIGH, f);
    end
    for (int i = 0; i < 6; i++) f[i] = $urandom;
    if ($urandom_range(15) != 0) send_word(pcfa_pkg::KIND_FINISH, f);
  endtask

  initial begin
    logic [31:0] f[6];
    rst_ni = 1'b0; probe.stall_hold = 1'b0;
    send_idle_pct = 13; recv_idle_pct = 53;
    in_ch.valid = 1'b0; in_ch.kind = pcfa_pkg::KIND_START;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.vel_x = '0; in_ch.vel_y = '0; in_ch.vel_z = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: finish with no start, extremes, coincident and far neighbours, unused kind.
    foreach (f[i]) f[i] = '0;
    send_word(pcfa_pkg::KIND_FINISH, f);
    send_word(pcfa_pkg::KIND_NEIGH, f);
    send_word(pcfa_pkg::KIND_NONE, f);
    f = '{32'h0001_0000, 32'h0005_0000, 32'h0, 32'h0002_0000, 32'hFFFF_0000, 32'h0};
    send_word(pcfa_pkg::KIND_START, f);
    send_word(pcfa_pkg::KIND_NEIGH, f);
    f = '{32'h0001_8000, 32'h0005_4000, 32'h0000_2000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1};
    send_word(pcfa_pkg::KIND_NEIGH, f);
    f = '{32'h0009_0000, 32'h0005_0000, 32'h0, 0, 0, 0};
    send_word(pcfa_pkg::KIND_NEIGH, f);
    send_word(pcfa_pkg::KIND_FINISH, f);
    f = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    send_word(pcfa_pkg::KIND_START, f);
    send_word(pcfa_pkg::KIND_NEIGH, f);
    send_word(pcfa_pkg::KIND_FINISH, f);
    f = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0};
    send_word(pcfa_pkg::KIND_START, f);
    send_word(pcfa_pkg::KIND_FINISH, f);
    drain();

    // Extreme settings: largest coefficients saturate, zero radius disables contacts.
    write_cfg(pcfa_pkg::REG_RADIUS, 32'h7FFF_FFFF);
    write_cfg(pcfa_pkg::REG_HALF, 32'h0);
    write_cfg(pcfa_pkg::REG_SPRING, 32'hFFFF_FFFF);
    write_cfg(pcfa_pkg::REG_DAMP, 32'h7FFF_FFFF);
    f = '{32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678};
    send_word(pcfa_pkg::KIND_START, f);
    f = '{32'h3000_0000, 32'hD000_0000, 32'h1000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
    send_word(pcfa_pkg::KIND_NEIGH, f);
    send_word(pcfa_pkg::KIND_FINISH, f);
    drain();
    write_cfg(pcfa_pkg::REG_RADIUS, 32'h0);
    write_cfg(pcfa_pkg::REG_SPRING, 32'h0);
    write_cfg(pcfa_pkg::REG_DAMP, 32'h0);
    send_word(pcfa_pkg::KIND_NEIGH, f);
    send_word(pcfa_pkg::KIND_FINISH, f);
    drain();

    // Random phases, each under its own setting; the idling mix changes at phases 2 and 4.
    for (int ph = 0; ph < 6; ph++) begin
      int unsigned spread;
      if (ph == 2) begin send_idle_pct = 53; recv_idle_pct = 13; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_cfg(pcfa_pkg::REG_RADIUS,
                (ph == 5) ? 32'h0100_0000 : 32'($urandom_range(200000, 1)));
      write_cfg(pcfa_pkg::REG_HALF, (ph == 3) ? 32'h7FFF_FFFF : 32'($urandom_range(1000000)));
      write_cfg(pcfa_pkg::REG_SPRING, (ph == 1) ? 32'h7FFF_FFFF : 32'($urandom_range(300000)));
      write_cfg(pcfa_pkg::REG_DAMP, (ph == 1) ? 32'h7FFF_FFFF : 32'($urandom_range(70000)));
      spread = (ph == 5) ? 32'h1000_0000 : 32'($urandom_range(1500000, 100000));
      if (ph == 2) begin
        // Hold the result side off while finishes keep arriving, so input stalls.
        fork
          begin
            probe.stall_hold = 1'b1;
            repeat (3000) @(negedge clk_i);
            probe.stall_hold = 1'b0;
          end
          repeat (4) begin
            foreach (f[i]) f[i] = $urandom;
            send_word(pcfa_pkg::KIND_FINISH, f);
          end
        join
      end
      for (int n = 0; n < 62; n++) run_particle(spread);
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/pcfa_pkg.sv
rtl/pcfa_in_if.sv
rtl/pcfa_out_if.sv
rtl/pcfa_cfg_if.sv
rtl/particle_contact_force_accumulator_top.sv
tb/pcfa_tb_if.sv
tb/particle_contact_force_accumulator_top_tb.sv
